[design/ipv6v_pkg.sv]
`default_nettype none

package ipv6v_pkg;

   // character classes found by the front end
   localparam logic [2:0] CLS_COLON = 3'd0;
   localparam logic [2:0] CLS_DOT   = 3'd1;
   localparam logic [2:0] CLS_DEC   = 3'd2;
   localparam logic [2:0] CLS_HEXA  = 3'd3;
   localparam logic [2:0] CLS_OTHER = 3'd4;

   // queue depth between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // classified word handed from front to back
   typedef struct packed {
      logic [2:0] cls;
      logic [3:0] digit;
      logic       last;
      logic       end_only;
   } word_type;

endpackage

`default_nettype wire

[design/ipv6v_if.sv]
`default_nettype none

// request channel: one character word
interface ipv6v_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;
   logic       end_only;

   modport source (output valid, output ch, output last, output end_only, input ready);
   modport sink (input valid, input ch, input last, input end_only, output ready);
endinterface

// response channel: one verdict word
interface ipv6v_rsp_if;
   logic valid;
   logic ready;
   logic valid_res;

   modport source (output valid, output valid_res, input ready);
   modport sink (input valid, input valid_res, output ready);
endinterface

`default_nettype wire

[design/ipv6_address_validator_top.sv]
// an ending word passes the queue, then the verdict register, before its verdict is offered
// throughput: one character word per cycle, set by the back end's single-step parser, while no ending
// word meets an untaken verdict; a two-word queue parts intake from parser, a register holds the verdict
// reset: synchronous, active high; clears parser state, queue and response valid
`default_nettype none

module ipv6_address_validator_top (
   input  logic        clock,
   input  logic        reset,
   ipv6v_req_if.sink   req_chan,
   ipv6v_rsp_if.source rsp_chan
);

   logic                front_valid;
   logic                front_ready;
   ipv6v_pkg::word_type front_word;
   logic                back_valid;
   logic                back_ready;
   ipv6v_pkg::word_type back_word;

   // character intake and classification
   ipv6v_front u_front (
      .req_chan   (req_chan),
      .word_valid (front_valid),
      .word       (front_word),
      .word_ready (front_ready)
   );

   // decoupling queue
   ipv6v_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_word  (front_word),
      .push_ready (front_ready),
      .pop_valid  (back_valid),
      .pop_word   (back_word),
      .pop_ready  (back_ready)
   );

   // parser and verdict
   ipv6v_back u_back (
      .clock      (clock),
      .reset      (reset),
      .word_valid (back_valid),
      .word       (back_word),
      .word_ready (back_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

[design/ipv6v_front.sv]
`default_nettype none

module ipv6v_front (
   ipv6v_req_if.sink          req_chan,
   output logic               word_valid,
   output ipv6v_pkg::word_type word,
   input  logic               word_ready
);

   logic is_dec;
   logic is_alpha;

   // character class decode
   always_comb begin
      is_dec   = (req_chan.ch >= 8'h30) && (req_chan.ch <= 8'h39);
      is_alpha = ((req_chan.ch >= 8'h61) && (req_chan.ch <= 8'h66)) ||
                 ((req_chan.ch >= 8'h41) && (req_chan.ch <= 8'h46));
      word.digit    = req_chan.ch[3:0];
      word.last     = req_chan.last;
      word.end_only = req_chan.end_only;
      if (req_chan.ch == 8'h3a) begin
         word.cls = ipv6v_pkg::CLS_COLON;
      end else if (req_chan.ch == 8'h2e) begin
         word.cls = ipv6v_pkg::CLS_DOT;
      end else if (is_dec) begin
         word.cls = ipv6v_pkg::CLS_DEC;
      end else if (is_alpha) begin
         word.cls = ipv6v_pkg::CLS_HEXA;
      end else begin
         word.cls = ipv6v_pkg::CLS_OTHER;
      end
   end

   // handshake pass to the queue
   assign word_valid     = req_chan.valid;
   assign req_chan.ready = word_ready;

endmodule

`default_nettype wire

[design/ipv6v_queue.sv]
`default_nettype none

module ipv6v_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  ipv6v_pkg::word_type push_word,
   output logic                push_ready,
   output logic                pop_valid,
   output ipv6v_pkg::word_type pop_word,
   input  logic                pop_ready
);

   localparam int unsigned PTR_W = $clog2(ipv6v_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(ipv6v_pkg::QUEUE_DEPTH + 1);

   ipv6v_pkg::word_type entry_ff [ipv6v_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(ipv6v_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_word   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(ipv6v_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(ipv6v_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

[design/ipv6v_back.sv]
`default_nettype none

module ipv6v_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                word_valid,
   input  ipv6v_pkg::word_type word,
   output logic                word_ready,
   ipv6v_rsp_if.source         rsp_chan
);

   localparam logic [2:0] PH_START    = 3'd0;
   localparam logic [2:0] PH_COLON0   = 3'd1;
   localparam logic [2:0] PH_AFTER_DC = 3'd2;
   localparam logic [2:0] PH_HEX      = 3'd3;
   localparam logic [2:0] PH_DEC      = 3'd4;
   localparam logic [2:0] PH_COLON    = 3'd5;
   localparam logic [2:0] PH_V4       = 3'd6;
   localparam logic [9:0] BAD_OCTET   = 10'd1023;

   typedef struct packed {
      logic [9:0] value;
      logic [2:0] digits;
   } octet_type;

   function automatic octet_type octet_add(input octet_type cur, input logic [3:0] d);
      octet_type  res;
      logic [11:0] nv;
      nv = 12'({cur.value[7:0], 3'b000}) + 12'({cur.value[7:0], 1'b0}) + 12'(d);
      if ((cur.value > 10'd255) || ((cur.digits != '0) && (cur.value == '0)) ||
          (nv > 12'd255)) begin
         res.value = BAD_OCTET;
      end else begin
         res.value = nv[9:0];
      end
      res.digits = (cur.digits < 3'd7) ? cur.digits + 1'b1 : cur.digits;
      return res;
   endfunction

   function automatic logic octet_good(input octet_type cur);
      return (cur.digits != '0) && (cur.value <= 10'd255);
   endfunction

   logic [2:0] phase_ff, phase_in;
   logic [3:0] group_ff, group_in;
   logic [2:0] digit_ff, digit_in;
   logic       dc_ff, dc_in;
   logic       rej_ff, rej_in;
   logic [1:0] oct_idx_ff, oct_idx_in;
   octet_type  oct_ff, oct_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_res_ff, rsp_res_in;

   logic       bad;
   logic       ends;
   logic       pop;
   logic       is_hex;
   logic [4:0] total;
   logic       verdict;

   assign ends       = word.last || word.end_only;
   assign word_ready = !ends || !rsp_valid_ff || rsp_chan.ready;
   assign pop        = word_valid && word_ready;
   assign is_hex     = (word.cls == ipv6v_pkg::CLS_DEC) || (word.cls == ipv6v_pkg::CLS_HEXA);

   // parser step for one character
   always_comb begin
      phase_in   = phase_ff;
      group_in   = group_ff;
      digit_in   = digit_ff;
      dc_in      = dc_ff;
      oct_idx_in = oct_idx_ff;
      oct_in     = oct_ff;
      bad        = 1'b0;
      if (!word.end_only && !rej_ff) begin
         unique case (phase_ff)
            PH_START, PH_AFTER_DC, PH_COLON: begin
               if ((word.cls == ipv6v_pkg::CLS_COLON) && (phase_ff == PH_START)) begin
                  phase_in = PH_COLON0;
               end else if ((word.cls == ipv6v_pkg::CLS_COLON) && (phase_ff == PH_COLON)) begin
                  if (dc_ff) begin
                     bad = 1'b1;
                  end else begin
                     dc_in    = 1'b1;
                     phase_in = PH_AFTER_DC;
                  end
               end else if (is_hex) begin
                  // open a new group
                  digit_in = 3'd1;
                  oct_in   = '0;
                  if (word.cls == ipv6v_pkg::CLS_DEC) begin
                     oct_in   = octet_add('0, word.digit);
                     phase_in = PH_DEC;
                  end else begin
                     phase_in = PH_HEX;
                  end
               end else begin
                  bad = 1'b1;
               end
            end
            PH_COLON0: begin
               if (word.cls == ipv6v_pkg::CLS_COLON) begin
                  dc_in    = 1'b1;
                  phase_in = PH_AFTER_DC;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_HEX, PH_DEC: begin
               if (word.cls == ipv6v_pkg::CLS_COLON) begin
                  // close the group
                  digit_in = '0;
                  group_in = (group_ff < 4'd15) ? group_ff + 1'b1 : group_ff;
                  phase_in = PH_COLON;
               end else if ((word.cls == ipv6v_pkg::CLS_DOT) && (phase_ff == PH_DEC)) begin
                  if (octet_good(oct_ff)) begin
                     phase_in   = PH_V4;
                     oct_idx_in = 2'd1;
                     oct_in     = '0;
                  end else begin
                     bad = 1'b1;
                  end
               end else if (is_hex) begin
                  if (digit_ff >= 3'd4) begin
                     bad = 1'b1;
                  end else begin
                     digit_in = digit_ff + 1'b1;
                     if ((phase_ff == PH_DEC) && (word.cls == ipv6v_pkg::CLS_DEC)) begin
                        oct_in = octet_add(oct_ff, word.digit);
                     end else begin
                        phase_in = PH_HEX;
                     end
                  end
               end else begin
                  bad = 1'b1;
               end
            end
            PH_V4: begin
               if (word.cls == ipv6v_pkg::CLS_DEC) begin
                  oct_in = octet_add(oct_ff, word.digit);
               end else if ((word.cls == ipv6v_pkg::CLS_DOT) && (oct_idx_ff < 2'd3) &&
                            octet_good(oct_ff)) begin
                  oct_idx_in = oct_idx_ff + 1'b1;
                  oct_in     = '0;
               end else begin
                  bad = 1'b1;
               end
            end
            default: begin
               bad = 1'b1;
            end
         endcase
      end
      rej_in = rej_ff || bad;
   end

   // end of text verdict
   always_comb begin
      total   = {1'b0, group_in};
      verdict = 1'b0;
      unique case (phase_in)
         PH_START, PH_AFTER_DC: begin
            verdict = 1'b1;
         end
         PH_HEX, PH_DEC: begin
            total   = {1'b0, group_in} + 5'd1;
            verdict = 1'b1;
         end
         PH_V4: begin
            total   = {1'b0, group_in} + 5'd2;
            verdict = (oct_idx_in == 2'd3) && octet_good(oct_in);
         end
         default: begin
            verdict = 1'b0;
         end
      endcase
      rsp_res_in = !rej_in && verdict && (dc_in ? (total <= 5'd7) : (total == 5'd8));
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop && ends) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         group_ff     <= '0;
         digit_ff     <= '0;
         dc_ff        <= 1'b0;
         rej_ff       <= 1'b0;
         oct_idx_ff   <= '0;
         oct_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            if (ends) begin
               phase_ff   <= PH_START;
               group_ff   <= '0;
               digit_ff   <= '0;
               dc_ff      <= 1'b0;
               rej_ff     <= 1'b0;
               oct_idx_ff <= '0;
               oct_ff     <= '0;
            end else begin
               phase_ff   <= phase_in;
               group_ff   <= group_in;
               digit_ff   <= digit_in;
               dc_ff      <= dc_in;
               rej_ff     <= rej_in;
               oct_idx_ff <= oct_idx_in;
               oct_ff     <= oct_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && ends) begin
         rsp_res_ff <= rsp_res_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.valid_res = rsp_res_ff;

endmodule

`default_nettype wire
